// ===== rtl/qbrc_pkg.sv =====
package qbrc_pkg;

  // escape and saturation codes
  localparam logic [7:0] ESC_BASE     = 8'hfe;
  localparam logic [7:0] ESC_EXT1     = 8'hfa;
  localparam logic [7:0] BASE_ONES    = 8'hff;
  localparam logic [7:0] E2_HI_FIRST  = 8'ha2;
  localparam logic [7:0] E2_HI_LAST   = 8'hf6;
  localparam logic [7:0] E2_MID_FIRST = 8'h3e;
  localparam logic [7:0] E2_MID_LAST  = 8'ha1;
  localparam logic [7:0] E1_HI_FIRST  = 8'hbb;
  localparam logic [7:0] E1_HI_LAST   = 8'hf9;
  localparam logic [7:0] E1_MID_FIRST = 8'h4b;
  localparam logic [7:0] E1_MID_LAST  = 8'hba;
  localparam logic [7:0] BASE_HI_BIT  = 8'h80;
  localparam logic [7:0] BASE_MID_BIT = 8'h40;

  localparam logic [31:0] KBPS_ONES   = 32'hffff_ffff;
  localparam logic [31:0] KBPS_E1_DEF = 32'd8640;

  // encode segment thresholds
  localparam logic [31:0] RATE_MAX    = 32'd10000000;
  localparam logic [31:0] THR_E2_HI   = 32'd1600000;
  localparam logic [31:0] THR_E2_MID  = 32'd510000;
  localparam logic [31:0] THR_E2_LO   = 32'd260000;
  localparam logic [31:0] THR_E1_HI   = 32'd130000;
  localparam logic [31:0] THR_E1_MID  = 32'd17000;
  localparam logic [31:0] THR_E1_LO   = 32'd8700;
  localparam logic [31:0] THR_B_HI    = 32'd576;
  localparam logic [31:0] THR_B_MID   = 32'd64;

  // segment start values (decode base, encode offset origin)
  localparam logic [23:0] START_E2_HI  = 24'd1500000;
  localparam logic [23:0] START_E2_MID = 24'd500000;
  localparam logic [23:0] START_E2_LO  = 24'd256000;
  localparam logic [23:0] START_E1_HI  = 24'd128000;
  localparam logic [23:0] START_E1_MID = 24'd16000;
  localparam logic [23:0] START_E1_LO  = 24'd8600;
  localparam logic [23:0] START_B_HI   = 24'd576;
  localparam logic [23:0] START_B_MID  = 24'd64;
  localparam logic [23:0] START_B_LO   = 24'd0;

  localparam logic [23:0] OFF_SAT = 24'(RATE_MAX) - START_E2_HI;

  localparam logic [16:0] STEP_E2_HI  = 17'd100000;
  localparam logic [16:0] STEP_E2_MID = 17'd10000;
  localparam logic [16:0] STEP_E2_LO  = 17'd4000;
  localparam logic [16:0] STEP_E1_HI  = 17'd2000;
  localparam logic [16:0] STEP_E1_MID = 17'd1000;
  localparam logic [16:0] STEP_E1_LO  = 17'd100;
  localparam logic [16:0] STEP_B_HI   = 17'd64;
  localparam logic [16:0] STEP_B_MID  = 17'd8;
  localparam logic [16:0] STEP_B_LO   = 17'd1;

  // reciprocals floor(2^RCP_SHIFT / step); quotient comes out low by at most one
  localparam int unsigned RCP_SHIFT = 24;
  localparam int unsigned Q_W = 8;
  localparam logic [24:0] RCP_E2_HI  = 25'((64'd1 << RCP_SHIFT) / 64'(STEP_E2_HI));
  localparam logic [24:0] RCP_E2_MID = 25'((64'd1 << RCP_SHIFT) / 64'(STEP_E2_MID));
  localparam logic [24:0] RCP_E2_LO  = 25'((64'd1 << RCP_SHIFT) / 64'(STEP_E2_LO));
  localparam logic [24:0] RCP_E1_HI  = 25'((64'd1 << RCP_SHIFT) / 64'(STEP_E1_HI));
  localparam logic [24:0] RCP_E1_MID = 25'((64'd1 << RCP_SHIFT) / 64'(STEP_E1_MID));
  localparam logic [24:0] RCP_E1_LO  = 25'((64'd1 << RCP_SHIFT) / 64'(STEP_E1_LO));
  localparam logic [24:0] RCP_B_HI   = 25'((64'd1 << RCP_SHIFT) / 64'(STEP_B_HI));
  localparam logic [24:0] RCP_B_MID  = 25'((64'd1 << RCP_SHIFT) / 64'(STEP_B_MID));
  localparam logic [24:0] RCP_B_LO   = 25'((64'd1 << RCP_SHIFT) / 64'(STEP_B_LO));

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW = $clog2(QDEPTH);

  typedef enum logic {
    OP_DEC = 1'b0,
    OP_ENC = 1'b1
  } op_t;

  typedef enum logic [3:0] {
    SEG_E2_HI,
    SEG_E2_MID,
    SEG_E2_LO,
    SEG_E1_HI,
    SEG_E1_MID,
    SEG_E1_LO,
    SEG_B_HI,
    SEG_B_MID,
    SEG_B_LO
  } seg_t;

  typedef enum logic [1:0] {
    SP_NONE,
    SP_ONES,
    SP_E1_DEF,
    SP_ZERO
  } spec_t;

  // val: encode offset from segment start, or decode index in [7:0]
  typedef struct packed {
    op_t         op;
    seg_t        seg;
    spec_t       spec;
    logic [23:0] val;
  } item_t;

  typedef struct packed {
    logic [31:0] decoded_kbps;
    logic [7:0]  base_out;
    logic [7:0]  ext1_out;
    logic [7:0]  ext2_out;
    logic [1:0]  ext_level;
  } res_t;

  function automatic logic [23:0] seg_start(seg_t s);
    logic [23:0] v;
    case (s)
      SEG_E2_HI:  v = START_E2_HI;
      SEG_E2_MID: v = START_E2_MID;
      SEG_E2_LO:  v = START_E2_LO;
      SEG_E1_HI:  v = START_E1_HI;
      SEG_E1_MID: v = START_E1_MID;
      SEG_E1_LO:  v = START_E1_LO;
      SEG_B_HI:   v = START_B_HI;
      SEG_B_MID:  v = START_B_MID;
      default:    v = START_B_LO;
    endcase
    return v;
  endfunction

  function automatic logic [16:0] seg_step(seg_t s);
    logic [16:0] v;
    case (s)
      SEG_E2_HI:  v = STEP_E2_HI;
      SEG_E2_MID: v = STEP_E2_MID;
      SEG_E2_LO:  v = STEP_E2_LO;
      SEG_E1_HI:  v = STEP_E1_HI;
      SEG_E1_MID: v = STEP_E1_MID;
      SEG_E1_LO:  v = STEP_E1_LO;
      SEG_B_HI:   v = STEP_B_HI;
      SEG_B_MID:  v = STEP_B_MID;
      default:    v = STEP_B_LO;
    endcase
    return v;
  endfunction

  function automatic logic [24:0] seg_recip(seg_t s);
    logic [24:0] v;
    case (s)
      SEG_E2_HI:  v = RCP_E2_HI;
      SEG_E2_MID: v = RCP_E2_MID;
      SEG_E2_LO:  v = RCP_E2_LO;
      SEG_E1_HI:  v = RCP_E1_HI;
      SEG_E1_MID: v = RCP_E1_MID;
      SEG_E1_LO:  v = RCP_E1_LO;
      SEG_B_HI:   v = RCP_B_HI;
      SEG_B_MID:  v = RCP_B_MID;
      default:    v = RCP_B_LO;
    endcase
    return v;
  endfunction

  // code that a segment's start value maps to; the code is this plus the index
  function automatic logic [7:0] seg_code(seg_t s);
    logic [7:0] v;
    case (s)
      SEG_E2_HI:  v = 8'ha1;
      SEG_E2_MID: v = 8'h3d;
      SEG_E1_HI:  v = 8'hba;
      SEG_E1_MID: v = 8'h4a;
      SEG_B_HI:   v = BASE_HI_BIT;
      SEG_B_MID:  v = BASE_MID_BIT;
      default:    v = 8'h00;
    endcase
    return v;
  endfunction

  // highest code a segment can encode to, where a gap rate saturates
  function automatic logic [7:0] seg_cap(seg_t s);
    logic [7:0] v;
    case (s)
      SEG_E2_HI:  v = E2_HI_LAST;
      SEG_E2_MID: v = E2_MID_LAST;
      SEG_E2_LO:  v = 8'h3d;
      SEG_E1_HI:  v = ESC_EXT1;
      SEG_E1_MID: v = E1_MID_LAST;
      SEG_E1_LO:  v = 8'h4a;
      SEG_B_HI:   v = ESC_BASE;
      default:    v = 8'hff;
    endcase
    return v;
  endfunction

  function automatic logic [1:0] seg_lvl(seg_t s);
    logic [1:0] v;
    case (s)
      SEG_E2_HI, SEG_E2_MID, SEG_E2_LO: v = 2'd2;
      SEG_E1_HI, SEG_E1_MID, SEG_E1_LO: v = 2'd1;
      default:                          v = 2'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/qbrc_front.sv =====
module qbrc_front import qbrc_pkg::*; (
  input  logic        action,
  input  logic [31:0] rate_kbps,
  input  logic [7:0]  base_octet,
  input  logic [7:0]  ext1_octet,
  input  logic        ext1_present,
  input  logic [7:0]  ext2_octet,
  input  logic        ext2_present,
  output item_t       item
);

  seg_t        enc_seg;
  seg_t        dec_seg;
  spec_t       enc_spec;
  spec_t       dec_spec;
  logic [7:0]  dec_code;
  logic [7:0]  dec_idx;
  logic [31:0] enc_diff;
  logic        enc_sat;

  // encode: pick the segment by thresholds, offset from its start
  always_comb begin
    enc_spec = SP_NONE;
    enc_sat  = 1'b0;
    if (rate_kbps > RATE_MAX) begin
      enc_seg = SEG_E2_HI;
      enc_sat = 1'b1;
    end else if (rate_kbps >= THR_E2_HI) begin
      enc_seg = SEG_E2_HI;
    end else if (rate_kbps >= THR_E2_MID) begin
      enc_seg = SEG_E2_MID;
    end else if (rate_kbps >= THR_E2_LO) begin
      enc_seg = SEG_E2_LO;
    end else if (rate_kbps >= THR_E1_HI) begin
      enc_seg = SEG_E1_HI;
    end else if (rate_kbps >= THR_E1_MID) begin
      enc_seg = SEG_E1_MID;
    end else if (rate_kbps >= THR_E1_LO) begin
      enc_seg = SEG_E1_LO;
    end else if (rate_kbps >= THR_B_HI) begin
      enc_seg = SEG_B_HI;
    end else if (rate_kbps >= THR_B_MID) begin
      enc_seg = SEG_B_MID;
    end else begin
      enc_seg = SEG_B_LO;
      if (rate_kbps == 32'd0) begin
        enc_spec = SP_ZERO;
      end
    end
  end

  assign enc_diff = rate_kbps - {8'd0, seg_start(enc_seg)};

  // decode: pick the segment from the octets
  always_comb begin
    dec_spec = SP_NONE;
    dec_seg  = SEG_B_LO;
    dec_code = base_octet;
    if (base_octet == BASE_ONES) begin
      dec_spec = SP_ONES;
    end else if (base_octet == ESC_BASE) begin
      if (!ext1_present || ext1_octet == 8'd0) begin
        dec_spec = SP_E1_DEF;
      end else if (ext1_octet == ESC_EXT1) begin
        // absent extended-2 reads as the 256000-kbps segment start
        dec_code = ext2_present ? ext2_octet : 8'd0;
        if (dec_code >= E2_HI_FIRST && dec_code <= E2_HI_LAST) begin
          dec_seg = SEG_E2_HI;
        end else if (dec_code >= E2_MID_FIRST && dec_code <= E2_MID_LAST) begin
          dec_seg = SEG_E2_MID;
        end else begin
          dec_seg = SEG_E2_LO;
        end
      end else begin
        dec_code = ext1_octet;
        if (ext1_octet >= E1_HI_FIRST && ext1_octet <= E1_HI_LAST) begin
          dec_seg = SEG_E1_HI;
        end else if (ext1_octet >= E1_MID_FIRST && ext1_octet <= E1_MID_LAST) begin
          dec_seg = SEG_E1_MID;
        end else begin
          dec_seg = SEG_E1_LO;
        end
      end
    end else if ((base_octet & BASE_HI_BIT) != 8'd0) begin
      dec_seg = SEG_B_HI;
    end else if ((base_octet & BASE_MID_BIT) != 8'd0) begin
      dec_seg = SEG_B_MID;
    end
  end

  assign dec_idx = dec_code - seg_code(dec_seg);

  always_comb begin
    if (action) begin
      item.op   = OP_ENC;
      item.seg  = enc_seg;
      item.spec = enc_spec;
      item.val  = enc_sat ? OFF_SAT : enc_diff[23:0];
    end else begin
      item.op   = OP_DEC;
      item.seg  = dec_seg;
      item.spec = dec_spec;
      item.val  = {16'd0, dec_idx};
    end
  end

endmodule

// ===== rtl/qbrc_queue.sv =====
module qbrc_queue import qbrc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t wr_item,
  output logic  full,
  input  logic  pop,
  output item_t rd_item,
  output logic  empty
);

  item_t            mem_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r;
  logic [QAW-1:0]   rd_ptr_r;
  logic [QAW:0]     count_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == (QAW+1)'(QDEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_item = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

// ===== rtl/qbrc_back.sv =====
module qbrc_back import qbrc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  item_valid,
  input  item_t item,
  output logic  item_pop,
  output logic  res_valid,
  output res_t  res,
  input  logic  res_pop
);

  logic            en;
  logic            v1_r;
  logic            v2_r;
  logic            v3_r;
  item_t           it1_r;
  item_t           it2_r;
  logic [Q_W-1:0]  q0_1_r;
  logic [Q_W-1:0]  q0_2_r;
  logic [23:0]     prod2_r;
  res_t            res_r;
  res_t            res_nxt;
  logic [48:0]     prod1;
  logic [7:0]      mul_a;
  logic [24:0]     prod2_full;
  logic [23:0]     rem;
  logic [Q_W-1:0]  q;
  logic [8:0]      code_sum;
  logic [7:0]      code;
  logic [7:0]      cap_v;
  logic [23:0]     dec_sum;

  // whole pipe moves together, stalls only when the output register is held
  assign en        = !v3_r || res_pop;
  assign item_pop  = en && item_valid;
  assign res_valid = v3_r;
  assign res       = res_r;

  // stage 1: quotient estimate by reciprocal
  assign prod1 = item.val * seg_recip(item.seg);

  // stage 2: quotient times step (encode) or index times step (decode)
  assign mul_a      = (it1_r.op == OP_DEC) ? it1_r.val[7:0] : q0_1_r;
  assign prod2_full = mul_a * seg_step(it1_r.seg);

  // stage 3: correct the estimate, saturate, place the octets; decode adds the segment start
  assign rem      = it2_r.val - prod2_r;
  assign q        = q0_2_r + Q_W'(rem >= 24'(seg_step(it2_r.seg)));
  assign code_sum = {1'b0, seg_code(it2_r.seg)} + {1'b0, q};
  assign cap_v    = seg_cap(it2_r.seg);
  assign code     = (code_sum > {1'b0, cap_v}) ? cap_v : code_sum[7:0];
  assign dec_sum  = seg_start(it2_r.seg) + prod2_r;

  always_comb begin
    res_nxt = '0;
    if (it2_r.op == OP_DEC) begin
      case (it2_r.spec)
        SP_ONES:   res_nxt.decoded_kbps = KBPS_ONES;
        SP_E1_DEF: res_nxt.decoded_kbps = KBPS_E1_DEF;
        default:   res_nxt.decoded_kbps = {8'd0, dec_sum};
      endcase
    end else if (it2_r.spec == SP_ZERO) begin
      res_nxt.base_out = BASE_ONES;
    end else begin
      res_nxt.ext_level = seg_lvl(it2_r.seg);
      case (seg_lvl(it2_r.seg))
        2'd2: begin
          res_nxt.base_out = ESC_BASE;
          res_nxt.ext1_out = ESC_EXT1;
          res_nxt.ext2_out = code;
        end
        2'd1: begin
          res_nxt.base_out = ESC_BASE;
          res_nxt.ext1_out = code;
        end
        default: begin
          res_nxt.base_out = code;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= item_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it1_r   <= item;
      q0_1_r  <= prod1[RCP_SHIFT +: Q_W];
      it2_r   <= it1_r;
      q0_2_r  <= q0_1_r;
      prod2_r <= prod2_full[23:0];
      res_r   <= res_nxt;
    end
  end

endmodule

// ===== rtl/qos_bit_rate_codec_unit.sv =====
// path: a beat goes from the queue through the it1, it2 and result registers
// one beat per cycle unless a held result stalls; 3 back stages, two multipliers
// a 4-entry queue between classifier and back pipeline absorbs result stalls
// reset: synchronous active-low rst_n empties the queue and the pipeline;
// after reset out_empty is high and in_full is low
module qos_bit_rate_codec_unit import qbrc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic        in_action,
  input  logic [31:0] in_rate_kbps,
  input  logic [7:0]  in_base_octet,
  input  logic [7:0]  in_ext1_octet,
  input  logic        in_ext1_present,
  input  logic [7:0]  in_ext2_octet,
  input  logic        in_ext2_present,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [31:0] out_decoded_kbps,
  output logic [7:0]  out_base_out,
  output logic [7:0]  out_ext1_out,
  output logic [7:0]  out_ext2_out,
  output logic [1:0]  out_ext_level
);

  item_t front_item;
  item_t q_item;
  logic  q_empty;
  logic  q_pop;
  logic  res_valid;
  res_t  res;

  qbrc_front u_front (
    .action       (in_action),
    .rate_kbps    (in_rate_kbps),
    .base_octet   (in_base_octet),
    .ext1_octet   (in_ext1_octet),
    .ext1_present (in_ext1_present),
    .ext2_octet   (in_ext2_octet),
    .ext2_present (in_ext2_present),
    .item         (front_item)
  );

  qbrc_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_push),
    .wr_item (front_item),
    .full    (in_full),
    .pop     (q_pop),
    .rd_item (q_item),
    .empty   (q_empty)
  );

  qbrc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (!q_empty),
    .item       (q_item),
    .item_pop   (q_pop),
    .res_valid  (res_valid),
    .res        (res),
    .res_pop    (out_pop)
  );

  assign out_empty        = !res_valid;
  assign out_decoded_kbps = res.decoded_kbps;
  assign out_base_out     = res.base_out;
  assign out_ext1_out     = res.ext1_out;
  assign out_ext2_out     = res.ext2_out;
  assign out_ext_level    = res.ext_level;

endmodule

// ===== rtl/qbrc_checker.sv =====
module qbrc_props import qbrc_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_full,
  input logic        out_empty,
  input logic        out_pop,
  input logic [31:0] out_decoded_kbps,
  input logic [7:0]  out_base_out,
  input logic [7:0]  out_ext1_out,
  input logic [7:0]  out_ext2_out,
  input logic [1:0]  out_ext_level
);

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  a_held_beat: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_decoded_kbps) &&
      $stable(out_base_out) && $stable(out_ext1_out) && $stable(out_ext2_out) &&
      $stable(out_ext_level))
    else $error("held result beat changed");

  a_lvl2_escapes: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_ext_level == 2'd2 |->
      out_base_out == ESC_BASE && out_ext1_out == ESC_EXT1 && out_ext2_out != 8'd0)
    else $error("extended-2 result without escape octets");

  a_lvl1_escapes: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_ext_level == 2'd1 |->
      out_base_out == ESC_BASE && out_ext2_out == 8'd0 && out_ext1_out != 8'd0)
    else $error("extended result with wrong octets");

  a_decode_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_decoded_kbps != 32'd0 |->
      out_base_out == 8'd0 && out_ext1_out == 8'd0 && out_ext2_out == 8'd0 &&
      out_ext_level == 2'd0)
    else $error("decode result carries encode octets");

endmodule

bind qos_bit_rate_codec_unit qbrc_props u_qbrc_props (.*);
